// ===== design/hierarchical_qam_soft_demapper_macros.svh =====
// Assertion macros for the hierarchical QAM soft demapper.
`ifndef HIERARCHICAL_QAM_SOFT_DEMAPPER_MACROS_SVH
`define HIERARCHICAL_QAM_SOFT_DEMAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define HQD_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define HQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HQD_ASSERT_HOLD(lbl, ante, cons, msg)
`define HQD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/hqd_pkg.sv =====
// Types, constants and helper functions of the hierarchical QAM soft demapper.
`timescale 1ns / 1ps
package hqd_pkg;

  localparam int MAX_TOTAL_BITS_DEF = 8;
  localparam int AXIS_MAX_BITS      = 6;
  localparam int LLR_CLAMP          = 20480;
  localparam int ALPHA_ONE          = 4096;

  localparam logic [2:0] REG_HP_BITS   = 3'd0;
  localparam logic [2:0] REG_LP_BITS   = 3'd1;
  localparam logic [2:0] REG_ALPHA     = 3'd2;
  localparam logic [2:0] REG_NORM      = 3'd3;
  localparam logic [2:0] REG_INV_NOISE = 3'd4;

  typedef struct packed {
    logic signed [15:0] rx_i;
    logic signed [15:0] rx_q;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] llr;
    logic               layer;
    logic [3:0]         bit_position;
    logic               last;
  } out_item_t;

  function automatic logic [AXIS_MAX_BITS-1:0] gray_dec(input logic [AXIS_MAX_BITS-1:0] g);
    logic [AXIS_MAX_BITS-1:0] b;
    b[AXIS_MAX_BITS-1] = g[AXIS_MAX_BITS-1];
    for (int i = AXIS_MAX_BITS - 2; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

  // PAM level 2n - (2^b - 1); code is already masked to b bits, so b = 0 gives 0
  function automatic logic signed [AXIS_MAX_BITS+1:0] pam_level(
      input logic [AXIS_MAX_BITS-1:0] code, input logic [3:0] nb);
    logic signed [AXIS_MAX_BITS+1:0] n2;
    logic signed [AXIS_MAX_BITS+1:0] off;
    n2  = signed'({1'b0, gray_dec(code), 1'b0});
    off = signed'((AXIS_MAX_BITS+2)'((1 << nb) - 1));
    return n2 - off;
  endfunction

endpackage

// ===== design/hierarchical_qam_soft_demapper.sv =====
// Hierarchical QAM max-log soft demapper: point scan pipeline, min tracking, LLR output.
`timescale 1ns / 1ps
`include "hierarchical_qam_soft_demapper_macros.svh"
// One symbol at a time. After a symbol is taken, the point counter issues one
// constellation point per cycle into a 7-stage pipeline (PAM, axis scaling,
// normalization, rounding, difference, square, sum) whose last stage feeds the
// per-bit minimum distances. A symbol passes through the idle state to take the
// request, a scan of all 2^(hp+lp) points, a drain of the pipeline and, per LLR,
// the magnitude, multiply, sum and output states, where an output stall holds
// it. A configuration with a zero layer or too many bits gives no LLRs and leaves
// the input free. The user must write configuration only while no symbol is in
// flight; the block itself does not enforce it.
module hierarchical_qam_soft_demapper
  import hqd_pkg::*;
#(
  parameter int MAX_TOTAL_BITS = MAX_TOTAL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TB   = MAX_TOTAL_BITS;
  localparam int TBW  = $clog2(TB + 1);
  localparam int KW   = $clog2(TB);
  localparam int AX   = (TB + 1) / 2;
  localparam int PW   = AX + 2;
  localparam int RW   = 17 + PW + AX + 1;
  localparam int PRW  = RW + 17;
  localparam int PXW  = PRW - 14;
  localparam int DXW  = PXW + 1;
  localparam int SQW  = 2 * DXW;
  localparam int DW   = SQW + 1;
  localparam int NST  = 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_MAG   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // configuration
  logic [3:0]  hp_cfg_r, lp_cfg_r;
  logic [15:0] alpha_cfg_r, norm_cfg_r, inv_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_cfg_r    <= 4'd2;
      lp_cfg_r    <= 4'd2;
      alpha_cfg_r <= 16'(ALPHA_ONE);
      norm_cfg_r  <= 16'hFFFF;
      inv_cfg_r   <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HP_BITS:   hp_cfg_r    <= cfg_data[3:0];
        REG_LP_BITS:   lp_cfg_r    <= cfg_data[3:0];
        REG_ALPHA:     alpha_cfg_r <= cfg_data;
        REG_NORM:      norm_cfg_r  <= cfg_data;
        REG_INV_NOISE: inv_cfg_r   <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // axis split of the current configuration
  logic [4:0] tot_c, ib_c, qb_c, hi_c, hq_c, hi0_c, hq0_c;
  logic       cfg_ok_c;
  always_comb begin
    tot_c = 5'(hp_cfg_r) + 5'(lp_cfg_r);
    ib_c  = (tot_c + 5'd1) >> 1;
    qb_c  = tot_c >> 1;
    hi0_c = (5'(hp_cfg_r) + 5'd1) >> 1;
    if (hi0_c > ib_c) hi0_c = ib_c;
    hq0_c = 5'(hp_cfg_r) - hi0_c;
    if (hq0_c > qb_c) begin
      hi_c = hi0_c + (hq0_c - qb_c);
      hq_c = qb_c;
    end else begin
      hi_c = hi0_c;
      hq_c = hq0_c;
    end
    cfg_ok_c = (hp_cfg_r != 4'd0) && (lp_cfg_r != 4'd0) && (tot_c <= 5'(TB));
  end

  // per-symbol registers
  state_t state_r, state_nxt;
  logic [3:0]  hp_r, lp_r, hi_r, hq_r, li_r, lq_r;
  logic [TBW-1:0] tot_r;
  logic [TB-1:0]  pmask_r, lmask_r;
  logic [16:0]    alpha_r;
  logic [15:0]    norm_r, inv_r;
  logic signed [15:0] rx_r, ry_r;
  logic [TB-1:0]  pcnt_r;
  logic [KW-1:0]  k_r;

  logic in_acc, out_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hp_r    <= hp_cfg_r;
      lp_r    <= lp_cfg_r;
      hi_r    <= hi_c[3:0];
      hq_r    <= hq_c[3:0];
      li_r    <= 4'(ib_c - hi_c);
      lq_r    <= 4'(qb_c - hq_c);
      tot_r   <= TBW'(tot_c);
      pmask_r <= TB'((1 << tot_c) - 1);
      lmask_r <= TB'((1 << lp_cfg_r) - 1);
      alpha_r <= (alpha_cfg_r < 16'(ALPHA_ONE)) ? 17'(ALPHA_ONE) : {1'b0, alpha_cfg_r};
      norm_r  <= norm_cfg_r;
      inv_r   <= inv_cfg_r;
      rx_r    <= in_data.rx_i;
      ry_r    <= in_data.rx_q;
    end
  end

  // scan pipeline
  logic [NST-1:0] sv_r;
  logic [TB-1:0]  idx_r [NST];
  logic signed [PW-1:0]  pam_hi_r, pam_li_r, pam_hq_r, pam_lq_r;
  logic signed [RW-1:0]  raw_x_r, raw_y_r;
  logic signed [PRW-1:0] prod_x_r, prod_y_r;
  logic signed [PXW-1:0] px_r, py_r;
  logic signed [DXW-1:0] dx_r, dy_r;
  logic [SQW-1:0]        sqx_r, sqy_r;
  logic [DW-1:0]         dist_r;
  logic [DW-1:0]         d0_r [TB];
  logic [DW-1:0]         d1_r [TB];

  logic issue;
  assign issue = (state_r == S_SCAN);

  // stage 1 inputs
  logic [TB-1:0] h_c, l_c;
  logic [AXIS_MAX_BITS-1:0] hiv_c, hqv_c, liv_c, lqv_c;
  always_comb begin
    h_c   = pcnt_r >> lp_r;
    l_c   = pcnt_r & lmask_r;
    hiv_c = AXIS_MAX_BITS'((h_c >> hq_r) & TB'((1 << hi_r) - 1));
    hqv_c = AXIS_MAX_BITS'(h_c & TB'((1 << hq_r) - 1));
    liv_c = AXIS_MAX_BITS'((l_c >> lq_r) & TB'((1 << li_r) - 1));
    lqv_c = AXIS_MAX_BITS'(l_c & TB'((1 << lq_r) - 1));
  end

  // rounding of the normalized coordinates
  logic [PRW-1:0] magx_c, magy_c;
  logic [PXW-1:0] rndx_c, rndy_c;
  always_comb begin
    magx_c = prod_x_r[PRW-1] ? PRW'(-prod_x_r) : PRW'(prod_x_r);
    magy_c = prod_y_r[PRW-1] ? PRW'(-prod_y_r) : PRW'(prod_y_r);
    rndx_c = PXW'((magx_c + PRW'(32768)) >> 16);
    rndy_c = PXW'((magy_c + PRW'(32768)) >> 16);
  end

  logic signed [RW-1:0] alpha_s;
  assign alpha_s = signed'(RW'(alpha_r));

  always_ff @(posedge clk) begin
    // stage 1: PAM levels
    pam_hi_r <= PW'(pam_level(hiv_c, hi_r));
    pam_hq_r <= PW'(pam_level(hqv_c, hq_r));
    pam_li_r <= PW'(pam_level(liv_c, li_r));
    pam_lq_r <= PW'(pam_level(lqv_c, lq_r));
    idx_r[0] <= pcnt_r << (TBW'(TB) - tot_r);  // MSB-aligned point index
    // stage 2: alpha scaling
    raw_x_r  <= ((alpha_s * RW'(pam_hi_r)) <<< li_r) + RW'(pam_li_r) * RW'(ALPHA_ONE);
    raw_y_r  <= ((alpha_s * RW'(pam_hq_r)) <<< lq_r) + RW'(pam_lq_r) * RW'(ALPHA_ONE);
    // stage 3: normalization
    prod_x_r <= PRW'(raw_x_r) * signed'(PRW'(norm_r));
    prod_y_r <= PRW'(raw_y_r) * signed'(PRW'(norm_r));
    // stage 4: round half away from zero
    px_r     <= prod_x_r[PRW-1] ? -signed'(rndx_c) : signed'(rndx_c);
    py_r     <= prod_y_r[PRW-1] ? -signed'(rndy_c) : signed'(rndy_c);
    // stage 5
    dx_r     <= DXW'(rx_r) - DXW'(px_r);
    dy_r     <= DXW'(ry_r) - DXW'(py_r);
    // stage 6
    sqx_r    <= SQW'(SQW'(dx_r) * SQW'(dx_r));
    sqy_r    <= SQW'(SQW'(dy_r) * SQW'(dy_r));
    // stage 7
    dist_r   <= DW'(sqx_r) + DW'(sqy_r);
    for (int s = 1; s < NST; s++) begin
      idx_r[s] <= idx_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else begin
      sv_r <= {sv_r[NST-2:0], issue};
    end
  end

  // per-bit minimum distances
  always_ff @(posedge clk) begin
    for (int b = 0; b < TB; b++) begin
      if (in_acc) begin
        d0_r[b] <= '1;
        d1_r[b] <= '1;
      end else if (sv_r[NST-1] && (TBW'(b) < tot_r)) begin
        if (!idx_r[NST-1][TB-1-b]) begin
          if (dist_r < d0_r[b]) d0_r[b] <= dist_r;
        end else if (dist_r < d1_r[b]) begin
          d1_r[b] <= dist_r;
        end
      end
    end
  end

  // LLR arithmetic
  logic [47:0] mag_r;
  logic        neg_r;
  logic [39:0] plo_r, phi_r;
  logic [DW-1:0] dk0_c, dk1_c, dif_c;
  logic [63:0]   dif64_c;
  logic [64:0]   sum_c;
  logic [42:0]   v_c;
  logic [15:0]   vc_c;
  logic [TBW-1:0] kx_c;
  logic          klast_c, klp_c;
  always_comb begin
    dk0_c   = d0_r[k_r];
    dk1_c   = d1_r[k_r];
    dif_c   = (dk1_c < dk0_c) ? dk0_c - dk1_c : dk1_c - dk0_c;
    dif64_c = 64'(dif_c);
    sum_c   = {1'b0, phi_r, 24'd0} + 65'(plo_r) + 65'(64'h20_0000);
    v_c     = sum_c[64:22];
    vc_c    = (v_c > 43'(LLR_CLAMP)) ? 16'(LLR_CLAMP) : v_c[15:0];
    kx_c    = TBW'(k_r);
    klast_c = (kx_c == tot_r - TBW'(1));
    klp_c   = (kx_c >= TBW'(hp_r));
  end

  out_item_t out_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (state_r == S_MAG) begin
      mag_r <= (dif64_c > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : dif64_c[47:0];
      neg_r <= (dk1_c < dk0_c);
    end
    if (state_r == S_MUL) begin
      plo_r <= 40'(mag_r[23:0]) * 40'(inv_r);
      phi_r <= 40'(mag_r[47:24]) * 40'(inv_r);
    end
    if (state_r == S_SUM) begin
      out_r.llr          <= neg_r ? -signed'(vc_c) : signed'(vc_c);
      out_r.layer        <= klp_c;
      out_r.bit_position <= klp_c ? 4'(kx_c - TBW'(hp_r)) : 4'(kx_c);
      out_r.last         <= klast_c;
    end
  end
  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = cfg_ok_c ? S_SCAN : S_IDLE;
      S_SCAN:  if (pcnt_r == pmask_r) state_nxt = S_DRAIN;
      S_DRAIN: if (sv_r == '0) state_nxt = S_MAG;
      S_MAG:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OUT;
      S_OUT:   if (out_acc) state_nxt = out_r.last ? S_IDLE : S_MAG;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcnt_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        pcnt_r <= '0;
        k_r    <= '0;
      end else begin
        if (issue) pcnt_r <= pcnt_r + TB'(1);
        if (state_r == S_OUT && out_acc) k_r <= k_r + KW'(1);
      end
      if (state_r == S_SUM) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
  end

  `HQD_ASSERT_HOLD(a_issue_in_scan, sv_r[0], $past(state_r == S_SCAN), "point issued outside scan")
  `HQD_ASSERT_HOLD(a_out_in_out_state, out_valid, state_r == S_OUT, "result shown outside output state")
  `HQD_ASSERT_NEXT(a_last_frees_input, out_acc && out_data.last, !in_stall, "input not freed after last LLR")
  `HQD_ASSERT_HOLD(a_k_in_range, state_r == S_OUT, TBW'(k_r) < tot_r, "LLR index beyond bit count")

endmodule
